FILE: rtl/mhub_pkg.sv
// mhub_pkg: shared types, codes and reset constants for the motor feedback and
// command hub. No dependencies.
`timescale 1ns / 1ps

package mhub_pkg;

  localparam int unsigned MOTORS_DEF   = 4;
  localparam int unsigned AGE_BITS_DEF = 24;

  localparam logic [3:0]  MIN_FEEDBACK_LEN = 4'd7;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned CFG_DATA_W       = 24;

  localparam logic        RST_BUS_ENABLED      = 1'b0;
  localparam logic [10:0] RST_FEEDBACK_ID_BASE = 11'd513;
  localparam logic [10:0] RST_COMMAND_ID       = 11'd512;
  localparam logic [15:0] RST_TX_INTERVAL      = 16'd1000;
  localparam logic [23:0] RST_FB_TIMEOUT       = 24'd100000;

  typedef enum logic [2:0] {
    REQ_FRAME    = 3'd0,
    REQ_SET_CMD  = 3'd1,
    REQ_TICK     = 3'd2,
    REQ_READ     = 3'd3,
    REQ_ZERO_ALL = 3'd4
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUS_ENABLED      = 3'd0,
    CFG_FEEDBACK_ID_BASE = 3'd1,
    CFG_COMMAND_ID       = 3'd2,
    CFG_TX_INTERVAL      = 3'd3,
    CFG_FB_TIMEOUT       = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [10:0]        frame_id;
    logic               frame_extended;
    logic               frame_remote;
    logic [3:0]         frame_length;
    logic [55:0]        frame_payload;
    logic [1:0]         motor_index;
    logic signed [15:0] command_value;
  } in_item_t;

  typedef struct packed {
    logic               tx_valid;
    logic [10:0]        tx_frame_id;
    logic [63:0]        tx_payload;
    logic [3:0]         fresh_mask;
    logic               frame_accepted;
    logic [15:0]        status_angle;
    logic signed [15:0] status_rpm;
    logic signed [15:0] status_current;
    logic [7:0]         status_temperature;
    logic [31:0]        sent_count;
    logic [31:0]        feedback_count;
  } out_item_t;

  // control from the decode stage to the feedback store
  typedef struct packed {
    logic       fb_write;
    logic [1:0] fb_motor;
    logic       tick;
  } fb_ctl_t;

  // control from the decode stage to the command side
  typedef struct packed {
    logic       set_cmd;
    logic [1:0] motor;
    logic       tick;
    logic       zero_all;
    logic       bus_en;
    logic       clr_interval;
  } cmd_ctl_t;

endpackage

FILE: rtl/mhub_req_if.sv
// mhub_req_if: request channel (valid/ready plus request fields).
// Depends on nothing.
`timescale 1ns / 1ps

interface mhub_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [10:0]        frame_id;
  logic               frame_extended;
  logic               frame_remote;
  logic [3:0]         frame_length;
  logic [55:0]        frame_payload;
  logic [1:0]         motor_index;
  logic signed [15:0] command_value;

  modport source (
    output valid, req_type, frame_id, frame_extended, frame_remote, frame_length,
           frame_payload, motor_index, command_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, frame_id, frame_extended, frame_remote, frame_length,
           frame_payload, motor_index, command_value,
    output ready
  );
endinterface

FILE: rtl/mhub_rsp_if.sv
// mhub_rsp_if: result channel (valid/ready plus result fields).
// Depends on nothing.
`timescale 1ns / 1ps

interface mhub_rsp_if;
  logic               valid;
  logic               ready;
  logic               tx_valid;
  logic [10:0]        tx_frame_id;
  logic [63:0]        tx_payload;
  logic [3:0]         fresh_mask;
  logic               frame_accepted;
  logic [15:0]        status_angle;
  logic signed [15:0] status_rpm;
  logic signed [15:0] status_current;
  logic [7:0]         status_temperature;
  logic [31:0]        sent_count;
  logic [31:0]        feedback_count;

  modport source (
    output valid, tx_valid, tx_frame_id, tx_payload, fresh_mask, frame_accepted,
           status_angle, status_rpm, status_current, status_temperature,
           sent_count, feedback_count,
    input  ready
  );
  modport sink (
    input  valid, tx_valid, tx_frame_id, tx_payload, fresh_mask, frame_accepted,
           status_angle, status_rpm, status_current, status_temperature,
           sent_count, feedback_count,
    output ready
  );
endinterface

FILE: rtl/mhub_feedback.sv
// mhub_feedback: per-motor feedback tables, entry ages and fresh mask.
// Depends on mhub_pkg.
`timescale 1ns / 1ps

module mhub_feedback #(
  parameter int unsigned MOTORS   = mhub_pkg::MOTORS_DEF,
  parameter int unsigned AGE_BITS = mhub_pkg::AGE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  mhub_pkg::fb_ctl_t  ctl_i,
  input  logic [55:0]        payload_i,
  input  logic [23:0]        timeout_i,
  input  logic [1:0]         rd_motor_i,
  output logic [3:0]         fresh_mask_o,
  output logic [15:0]        angle_o,
  output logic signed [15:0] rpm_o,
  output logic signed [15:0] current_o,
  output logic [7:0]         temperature_o
);
  import mhub_pkg::*;

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  logic [15:0]         angle_q [MOTORS];
  logic [15:0]         angle_d [MOTORS];
  logic [15:0]         rpm_q   [MOTORS];
  logic [15:0]         rpm_d   [MOTORS];
  logic [15:0]         cur_q   [MOTORS];
  logic [15:0]         cur_d   [MOTORS];
  logic [7:0]          temp_q  [MOTORS];
  logic [7:0]          temp_d  [MOTORS];
  logic [AGE_BITS-1:0] age_q   [MOTORS];
  logic [AGE_BITS-1:0] age_d   [MOTORS];
  logic [MOTORS-1:0]   vld_q;
  logic [MOTORS-1:0]   vld_d;

  always_comb begin
    for (int k = 0; k < MOTORS; k++) begin
      angle_d[k] = angle_q[k];
      rpm_d[k]   = rpm_q[k];
      cur_d[k]   = cur_q[k];
      temp_d[k]  = temp_q[k];
      age_d[k]   = age_q[k];
      vld_d[k]   = vld_q[k];
      if (fire_i && ctl_i.fb_write && ctl_i.fb_motor == 2'(k)) begin
        angle_d[k] = payload_i[55:40];
        rpm_d[k]   = payload_i[39:24];
        cur_d[k]   = payload_i[23:8];
        temp_d[k]  = payload_i[7:0];
        age_d[k]   = '0;
        vld_d[k]   = 1'b1;
      end else if (fire_i && ctl_i.tick && age_q[k] != AGE_MAX) begin
        age_d[k] = age_q[k] + AGE_BITS'(1);
      end
    end
  end

  // results report the state after this transaction
  always_comb begin
    fresh_mask_o  = '0;
    angle_o       = '0;
    rpm_o         = '0;
    current_o     = '0;
    temperature_o = '0;
    for (int k = 0; k < MOTORS; k++) begin
      fresh_mask_o[k] = vld_d[k] && (32'(age_d[k]) <= 32'(timeout_i));
      if (rd_motor_i == 2'(k)) begin
        angle_o       = angle_d[k];
        rpm_o         = rpm_d[k];
        current_o     = cur_d[k];
        temperature_o = temp_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MOTORS; k++) begin
        angle_q[k] <= '0;
        rpm_q[k]   <= '0;
        cur_q[k]   <= '0;
        temp_q[k]  <= '0;
        age_q[k]   <= '0;
      end
      vld_q <= '0;
    end else begin
      for (int k = 0; k < MOTORS; k++) begin
        angle_q[k] <= angle_d[k];
        rpm_q[k]   <= rpm_d[k];
        cur_q[k]   <= cur_d[k];
        temp_q[k]  <= temp_d[k];
        age_q[k]   <= age_d[k];
      end
      vld_q <= vld_d;
    end
  end

endmodule

FILE: rtl/mhub_command.sv
// mhub_command: current command table, send interval timer, frame packing
// and sent counter. Depends on mhub_pkg.
`timescale 1ns / 1ps

module mhub_command #(
  parameter int unsigned MOTORS = mhub_pkg::MOTORS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  mhub_pkg::cmd_ctl_t ctl_i,
  input  logic signed [15:0] value_i,
  input  logic [15:0]        interval_i,
  output logic               send_o,
  output logic [63:0]        payload_o,
  output logic [31:0]        sent_count_o
);
  import mhub_pkg::*;

  logic [15:0] cmd_q [MOTORS];
  logic [15:0] cmd_d [MOTORS];
  logic [15:0] elapsed_q;
  logic [15:0] elapsed_d;
  logic [15:0] elapsed_inc;
  logic [31:0] sent_q;
  logic [31:0] sent_d;

  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

  always_comb begin
    for (int k = 0; k < MOTORS; k++) begin
      cmd_d[k] = cmd_q[k];
      if (fire_i && ctl_i.zero_all) begin
        cmd_d[k] = '0;
      end else if (fire_i && ctl_i.set_cmd && ctl_i.motor == 2'(k)) begin
        cmd_d[k] = value_i;
      end
    end

    send_o    = 1'b0;
    elapsed_d = elapsed_q;
    if (ctl_i.clr_interval) begin
      elapsed_d = '0;
    end else if (fire_i && ctl_i.tick) begin
      if (!ctl_i.bus_en) begin
        elapsed_d = '0;
      end else if (elapsed_inc >= interval_i) begin
        elapsed_d = '0;
        send_o    = 1'b1;
      end else begin
        elapsed_d = elapsed_inc;
      end
    end else if (fire_i && ctl_i.zero_all && ctl_i.bus_en) begin
      send_o = 1'b1;
    end

    sent_d = (fire_i && send_o) ? sent_q + 32'd1 : sent_q;

    // motor k takes bytes 2k (high) and 2k+1, byte 0 on top
    payload_o = '0;
    for (int k = 0; k < MOTORS; k++) begin
      payload_o[63 - 16*k -: 16] = cmd_d[k];
    end
  end

  assign sent_count_o = sent_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MOTORS; k++) begin
        cmd_q[k] <= '0;
      end
      elapsed_q <= '0;
      sent_q    <= '0;
    end else begin
      for (int k = 0; k < MOTORS; k++) begin
        cmd_q[k] <= cmd_d[k];
      end
      elapsed_q <= elapsed_d;
      sent_q    <= sent_d;
    end
  end

endmodule

FILE: rtl/can_motor_feedback_and_command_hub_unit.sv
// Channel  Dir  Handshake    Payload
// req_i    in   valid/ready  request type, received frame, motor index, command
// rsp_o    out  valid/ready  command frame, fresh mask, status, counters
// cfg      in   cfg_we_i     cfg_idx_i selects register, cfg_wdata_i carries it
//
// One transaction per cycle sustained while rsp_o is ready; a request passes
// the input register, then decode and table update into the result register.
// All tables reset to zero with the reset; there is no clearing pass.
// A stalled result holds the result register; one more request waits in the
// input register, after which req_i.ready drops until rsp_o moves.
// Depends on mhub_pkg, mhub_req_if, mhub_rsp_if, mhub_feedback, mhub_command.
`timescale 1ns / 1ps

module can_motor_feedback_and_command_hub_unit #(
  parameter int unsigned MOTORS   = mhub_pkg::MOTORS_DEF,
  parameter int unsigned AGE_BITS = mhub_pkg::AGE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  mhub_req_if.sink                            req_i,
  mhub_rsp_if.source                          rsp_o,
  input  logic                                cfg_we_i,
  input  logic [mhub_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mhub_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import mhub_pkg::*;

  logic        bus_en_q;
  logic [10:0] fb_base_q;
  logic [10:0] cmd_id_q;
  logic [15:0] interval_q;
  logic [23:0] timeout_q;

  in_item_t    in_q;
  logic        in_vld_q;
  out_item_t   out_q;
  out_item_t   res_d;
  logic        out_vld_q;
  logic [31:0] acc_q;
  logic [31:0] acc_d;

  logic        proc_fire;
  logic        req_fire;
  logic [11:0] id_diff;
  logic        frame_hit;
  logic        clr_interval;
  fb_ctl_t     fb_ctl;
  cmd_ctl_t    cmd_ctl;
  logic        send;
  logic [63:0] tx_payload;
  logic [31:0] sent_count;

  logic [3:0]         fb_fresh;
  logic [15:0]        fb_angle;
  logic signed [15:0] fb_rpm;
  logic signed [15:0] fb_current;
  logic [7:0]         fb_temp;

  assign proc_fire   = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || proc_fire;
  assign req_fire    = req_i.valid && req_i.ready;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_en_q   <= RST_BUS_ENABLED;
      fb_base_q  <= RST_FEEDBACK_ID_BASE;
      cmd_id_q   <= RST_COMMAND_ID;
      interval_q <= RST_TX_INTERVAL;
      timeout_q  <= RST_FB_TIMEOUT;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BUS_ENABLED:      bus_en_q   <= cfg_wdata_i[0];
        CFG_FEEDBACK_ID_BASE: fb_base_q  <= cfg_wdata_i[10:0];
        CFG_COMMAND_ID:       cmd_id_q   <= cfg_wdata_i[10:0];
        CFG_TX_INTERVAL:      interval_q <= cfg_wdata_i[15:0];
        CFG_FB_TIMEOUT:       timeout_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // the timer only runs while enabled, so only a disabling write clears it
  assign clr_interval = cfg_we_i && (cfg_idx_i == CFG_BUS_ENABLED) && !cfg_wdata_i[0];

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_fire) begin
      in_vld_q <= 1'b1;
    end else if (proc_fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      in_q.req_type       <= req_i.req_type;
      in_q.frame_id       <= req_i.frame_id;
      in_q.frame_extended <= req_i.frame_extended;
      in_q.frame_remote   <= req_i.frame_remote;
      in_q.frame_length   <= req_i.frame_length;
      in_q.frame_payload  <= req_i.frame_payload;
      in_q.motor_index    <= req_i.motor_index;
      in_q.command_value  <= req_i.command_value;
    end
  end

  // decode
  assign id_diff   = {1'b0, in_q.frame_id} - {1'b0, fb_base_q};
  assign frame_hit = (in_q.req_type == REQ_FRAME) && bus_en_q &&
                     !in_q.frame_extended && !in_q.frame_remote &&
                     (in_q.frame_length >= MIN_FEEDBACK_LEN) &&
                     !id_diff[11] && (id_diff[10:0] < 11'(MOTORS));

  always_comb begin
    fb_ctl.fb_write = frame_hit;
    fb_ctl.fb_motor = id_diff[1:0];
    fb_ctl.tick     = (in_q.req_type == REQ_TICK);

    cmd_ctl.set_cmd      = (in_q.req_type == REQ_SET_CMD) &&
                           (32'(in_q.motor_index) < 32'(MOTORS));
    cmd_ctl.motor        = in_q.motor_index;
    cmd_ctl.tick         = (in_q.req_type == REQ_TICK);
    cmd_ctl.zero_all     = (in_q.req_type == REQ_ZERO_ALL);
    cmd_ctl.bus_en       = bus_en_q;
    cmd_ctl.clr_interval = clr_interval;
  end

  mhub_feedback #(
    .MOTORS   (MOTORS),
    .AGE_BITS (AGE_BITS)
  ) u_feedback (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (proc_fire),
    .ctl_i         (fb_ctl),
    .payload_i     (in_q.frame_payload),
    .timeout_i     (timeout_q),
    .rd_motor_i    (in_q.motor_index),
    .fresh_mask_o  (fb_fresh),
    .angle_o       (fb_angle),
    .rpm_o         (fb_rpm),
    .current_o     (fb_current),
    .temperature_o (fb_temp)
  );

  mhub_command #(
    .MOTORS (MOTORS)
  ) u_command (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (proc_fire),
    .ctl_i        (cmd_ctl),
    .value_i      (in_q.command_value),
    .interval_i   (interval_q),
    .send_o       (send),
    .payload_o    (tx_payload),
    .sent_count_o (sent_count)
  );

  assign acc_d = (proc_fire && frame_hit) ? acc_q + 32'd1 : acc_q;

  always_comb begin
    res_d.tx_valid           = send;
    res_d.tx_frame_id        = send ? cmd_id_q : '0;
    res_d.tx_payload         = send ? tx_payload : '0;
    res_d.fresh_mask         = fb_fresh;
    res_d.frame_accepted     = frame_hit;
    res_d.status_angle       = fb_angle;
    res_d.status_rpm         = fb_rpm;
    res_d.status_current     = fb_current;
    res_d.status_temperature = fb_temp;
    res_d.sent_count         = sent_count;
    res_d.feedback_count     = acc_d;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      acc_q     <= '0;
    end else begin
      acc_q <= acc_d;
      if (proc_fire) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      out_q <= res_d;
    end
  end

  assign rsp_o.valid              = out_vld_q;
  assign rsp_o.tx_valid           = out_q.tx_valid;
  assign rsp_o.tx_frame_id        = out_q.tx_frame_id;
  assign rsp_o.tx_payload         = out_q.tx_payload;
  assign rsp_o.fresh_mask         = out_q.fresh_mask;
  assign rsp_o.frame_accepted     = out_q.frame_accepted;
  assign rsp_o.status_angle       = out_q.status_angle;
  assign rsp_o.status_rpm         = out_q.status_rpm;
  assign rsp_o.status_current     = out_q.status_current;
  assign rsp_o.status_temperature = out_q.status_temperature;
  assign rsp_o.sent_count         = out_q.sent_count;
  assign rsp_o.feedback_count     = out_q.feedback_count;

  a_empty_output_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> req_i.ready)
    else $error("request stalled with empty result register");

  a_hit_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && frame_hit |=> out_vld_q && out_q.frame_accepted)
    else $error("accepted frame not reported");

  a_fb_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire |=> out_q.feedback_count == $past(acc_q) + 32'(out_q.frame_accepted))
    else $error("feedback count out of step");

  a_no_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.tx_valid |-> out_q.tx_payload == '0 && out_q.tx_frame_id == '0)
    else $error("frame fields set without a send");

endmodule

FILE: verif/can_motor_feedback_and_command_hub_unit_tb.sv
// Self-checking testbench for can_motor_feedback_and_command_hub_unit: random gaps and stalls
// on both channels, a cycle-free predictor of the hub, and field-by-field result checks.
// Depends on mhub_pkg, mhub_req_if, mhub_rsp_if and the hub RTL.
`timescale 1ns / 1ps

module can_motor_feedback_and_command_hub_unit_tb;
  import mhub_pkg::*;

  localparam int unsigned MOTORS         = MOTORS_DEF;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PHASE_ITEMS    = 165;
  localparam logic [2:0]  REQ_UNKNOWN_LO = 3'd5;
  localparam logic [2:0]  REQ_UNKNOWN_HI = 3'd7;
  localparam logic [AGE_BITS_DEF-1:0] AGE_SAT = '1;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  mhub_req_if req_if ();
  mhub_rsp_if rsp_if ();

  can_motor_feedback_and_command_hub_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // hub register copy
  logic        cfg_bus_en   = RST_BUS_ENABLED;
  logic [10:0] cfg_fb_base  = RST_FEEDBACK_ID_BASE;
  logic [10:0] cfg_cmd_id   = RST_COMMAND_ID;
  logic [15:0] cfg_interval = RST_TX_INTERVAL;
  logic [23:0] cfg_timeout  = RST_FB_TIMEOUT;

  // hub state copy
  logic [15:0] cmd_tbl   [MOTORS] = '{default: '0};
  logic [15:0] angle_tbl [MOTORS] = '{default: '0};
  logic [15:0] rpm_tbl   [MOTORS] = '{default: '0};
  logic [15:0] cur_tbl   [MOTORS] = '{default: '0};
  logic [7:0]  temp_tbl  [MOTORS] = '{default: '0};
  logic        fb_valid  [MOTORS] = '{default: 1'b0};
  logic [AGE_BITS_DEF-1:0] fb_age [MOTORS] = '{default: '0};
  logic [15:0] ticks_since_tx = '0;
  logic [31:0] frames_sent    = '0;
  logic [31:0] frames_taken   = '0;

  in_item_t  pending_requests[$];
  out_item_t expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned req_gap = 0;
  int unsigned rsp_hold = 0;
  int unsigned idle_cycles = 0;
  bit req_calm = 1'b0;
  bit rsp_calm = 1'b0;

  // Updates the hub state copy for one request and returns the result it must produce.
  function automatic out_item_t hub_apply_request(in_item_t rq);
    out_item_t   r;
    logic        send;
    int unsigned slot;
    r    = '0;
    send = 1'b0;
    case (rq.req_type)
      REQ_FRAME: begin
        if (cfg_bus_en && !rq.frame_extended && !rq.frame_remote &&
            rq.frame_length >= MIN_FEEDBACK_LEN && rq.frame_id >= cfg_fb_base &&
            int'(rq.frame_id) < int'(cfg_fb_base) + int'(MOTORS)) begin
          slot = 32'(rq.frame_id - cfg_fb_base);
          angle_tbl[slot] = rq.frame_payload[55:40];
          rpm_tbl[slot]   = rq.frame_payload[39:24];
          cur_tbl[slot]   = rq.frame_payload[23:8];
          temp_tbl[slot]  = rq.frame_payload[7:0];
          fb_valid[slot]  = 1'b1;
          fb_age[slot]    = '0;
          frames_taken++;
          r.frame_accepted = 1'b1;
        end
      end
      REQ_SET_CMD: cmd_tbl[rq.motor_index] = rq.command_value;
      REQ_TICK: begin
        for (int k = 0; k < MOTORS; k++) begin
          if (fb_age[k] != AGE_SAT) fb_age[k]++;
        end
        if (cfg_bus_en) begin
          if (ticks_since_tx != 16'hFFFF) ticks_since_tx++;
          if (ticks_since_tx >= cfg_interval) begin
            ticks_since_tx = '0;
            send = 1'b1;
          end
        end else begin
          ticks_since_tx = '0;
        end
      end
      REQ_ZERO_ALL: begin
        for (int k = 0; k < MOTORS; k++) cmd_tbl[k] = '0;
        send = cfg_bus_en;
      end
      default: ;
    endcase
    if (send) begin
      frames_sent++;
      r.tx_valid    = 1'b1;
      r.tx_frame_id = cfg_cmd_id;
      r.tx_payload  = {cmd_tbl[0], cmd_tbl[1], cmd_tbl[2], cmd_tbl[3]};
    end
    for (int k = 0; k < MOTORS; k++) begin
      r.fresh_mask[k] = fb_valid[k] && (fb_age[k] <= cfg_timeout);
    end
    r.status_angle       = angle_tbl[rq.motor_index];
    r.status_rpm         = rpm_tbl[rq.motor_index];
    r.status_current     = cur_tbl[rq.motor_index];
    r.status_temperature = temp_tbl[rq.motor_index];
    r.sent_count         = frames_sent;
    r.feedback_count     = frames_taken;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and stretches with none at all.
  function automatic int unsigned next_gap(inout bit calm);
    int unsigned pick;
    if (calm) begin
      if ($urandom_range(0, 39) == 0) calm = 1'b0;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t rand_item(logic [2:0] kind);
    in_item_t    it;
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    it.req_type       = kind;
    it.frame_id       = 11'($urandom_range(0, 2047));
    it.frame_extended = 1'($urandom_range(0, 1));
    it.frame_remote   = 1'($urandom_range(0, 1));
    it.frame_length   = 4'($urandom_range(0, 15));
    it.frame_payload  = raw[55:0];
    it.motor_index    = 2'($urandom_range(0, 3));
    it.command_value  = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  function automatic in_item_t frame_req(logic [10:0] id, logic ext, logic rtr,
                                         logic [3:0] len, logic [55:0] data);
    in_item_t it;
    it = rand_item(REQ_FRAME);
    it.frame_id       = id;
    it.frame_extended = ext;
    it.frame_remote   = rtr;
    it.frame_length   = len;
    it.frame_payload  = data;
    return it;
  endfunction

  function automatic in_item_t set_req(logic [1:0] motor, logic [15:0] value);
    in_item_t it;
    it = rand_item(REQ_SET_CMD);
    it.motor_index   = motor;
    it.command_value = value;
    return it;
  endfunction

  // Frames are mostly well-formed feedback in the current window, the rest is noise.
  function automatic in_item_t random_request();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it = rand_item(REQ_FRAME);
      if ($urandom_range(0, 3) != 0) begin
        it.frame_id       = 11'(cfg_fb_base + $urandom_range(0, MOTORS - 1));
        it.frame_extended = 1'b0;
        it.frame_remote   = 1'b0;
        it.frame_length   = 4'($urandom_range(MIN_FEEDBACK_LEN, 15));
      end else if ($urandom_range(0, 1) != 0) begin
        it.frame_id = 11'(cfg_fb_base + $urandom_range(0, MOTORS + 1) - 1);
      end
    end else if (pick < 60) it = rand_item(REQ_SET_CMD);
    else if (pick < 82) it = rand_item(REQ_TICK);
    else if (pick < 90) it = rand_item(REQ_READ);
    else if (pick < 94) it = rand_item(REQ_ZERO_ALL);
    else it = rand_item(3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI)));
    return it;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      if (mismatch_count < 10)
        $display("mismatch %s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [23:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_BUS_ENABLED:      cfg_bus_en   = value[0];
      CFG_FEEDBACK_ID_BASE: cfg_fb_base  = value[10:0];
      CFG_COMMAND_ID:       cfg_cmd_id   = value[10:0];
      CFG_TX_INTERVAL:      cfg_interval = value[15:0];
      CFG_FB_TIMEOUT:       cfg_timeout  = value[23:0];
      default: ;
    endcase
    if (!cfg_bus_en) ticks_since_tx = '0;
  endtask

  task automatic set_config(logic en, logic [10:0] base, logic [10:0] id,
                            logic [15:0] intv, logic [23:0] tmo);
    write_reg(CFG_BUS_ENABLED, 24'(en));
    write_reg(CFG_FEEDBACK_ID_BASE, 24'(base));
    write_reg(CFG_COMMAND_ID, 24'(id));
    write_reg(CFG_TX_INTERVAL, 24'(intv));
    write_reg(CFG_FB_TIMEOUT, tmo);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Checked on the falling edge so the driver and monitor have settled.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || req_if.valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) pending_requests.push_back(random_request());
    wait_idle();
  endtask

  // request driver
  always @(posedge clk_i) begin : req_driver
    in_item_t seen, nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        seen = {req_if.req_type, req_if.frame_id, req_if.frame_extended, req_if.frame_remote,
                req_if.frame_length, req_if.frame_payload, req_if.motor_index,
                req_if.command_value};
        expected_results.push_back(hub_apply_request(seen));
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_gap != 0) begin
          req_gap <= req_gap - 1;
          req_if.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          nxt = pending_requests.pop_front();
          {req_if.req_type, req_if.frame_id, req_if.frame_extended, req_if.frame_remote,
           req_if.frame_length, req_if.frame_payload, req_if.motor_index,
           req_if.command_value} <= nxt;
          req_if.valid <= 1'b1;
          req_gap <= next_gap(req_calm);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready generator
  always @(posedge clk_i) begin : rsp_monitor
    out_item_t got, want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = {rsp_if.tx_valid, rsp_if.tx_frame_id, rsp_if.tx_payload, rsp_if.fresh_mask,
               rsp_if.frame_accepted, rsp_if.status_angle, rsp_if.status_rpm,
               rsp_if.status_current, rsp_if.status_temperature, rsp_if.sent_count,
               rsp_if.feedback_count};
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected result transaction: %0h", got);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("tx_valid", 64'(want.tx_valid), 64'(got.tx_valid));
          check_field("tx_frame_id", 64'(want.tx_frame_id), 64'(got.tx_frame_id));
          check_field("tx_payload", want.tx_payload, got.tx_payload);
          check_field("fresh_mask", 64'(want.fresh_mask), 64'(got.fresh_mask));
          check_field("frame_accepted", 64'(want.frame_accepted),
                      64'(got.frame_accepted));
          check_field("status_angle", 64'(want.status_angle), 64'(got.status_angle));
          check_field("status_rpm", 64'(unsigned'(want.status_rpm)),
                      64'(unsigned'(got.status_rpm)));
          check_field("status_current", 64'(unsigned'(want.status_current)),
                      64'(unsigned'(got.status_current)));
          check_field("status_temperature", 64'(want.status_temperature),
                      64'(got.status_temperature));
          check_field("sent_count", 64'(want.sent_count), 64'(got.sent_count));
          check_field("feedback_count", 64'(want.feedback_count),
                      64'(got.feedback_count));
        end
      end
      if (rsp_hold != 0) begin
        rsp_if.ready <= 1'b0;
        rsp_hold <= rsp_hold - 1;
      end else begin
        rsp_if.ready <= 1'b1;
        rsp_hold <= next_gap(rsp_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_BUS_ENABLED;
    cfg_wdata_i          = '0;
    req_if.valid         = 1'b0;
    req_if.req_type      = REQ_READ;
    req_if.frame_id      = '0;
    req_if.frame_extended = 1'b0;
    req_if.frame_remote  = 1'b0;
    req_if.frame_length  = '0;
    req_if.frame_payload = '0;
    req_if.motor_index   = '0;
    req_if.command_value = '0;
    rsp_if.ready         = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // bus off after reset: frames dropped, nothing sent, commands still stored
    pending_requests.push_back(frame_req(11'd513, 1'b0, 1'b0, 4'd8, '1));
    pending_requests.push_back(set_req(2'd1, 16'h8000));
    pending_requests.push_back(rand_item(REQ_TICK));
    pending_requests.push_back(rand_item(REQ_ZERO_ALL));
    pending_requests.push_back(rand_item(REQ_UNKNOWN_HI));
    wait_idle();

    set_config(1'b1, 11'd513, 11'd512, 16'd2, 24'd2);
    pending_requests.push_back(frame_req(11'd513, 1'b0, 1'b0, 4'd7, '1));
    pending_requests.push_back(frame_req(11'd516, 1'b0, 1'b0, 4'd15, 56'h8001_7FFF_A5C3_5A));
    pending_requests.push_back(frame_req(11'd517, 1'b0, 1'b0, 4'd8, '1));
    pending_requests.push_back(frame_req(11'd512, 1'b0, 1'b0, 4'd8, '1));
    pending_requests.push_back(frame_req(11'd514, 1'b0, 1'b0, 4'd6, '1));
    pending_requests.push_back(frame_req(11'd514, 1'b1, 1'b0, 4'd8, '1));
    pending_requests.push_back(frame_req(11'd514, 1'b0, 1'b1, 4'd8, '1));
    pending_requests.push_back(frame_req(11'd515, 1'b0, 1'b0, 4'd8, '0));
    pending_requests.push_back(set_req(2'd0, 16'h7FFF));
    pending_requests.push_back(set_req(2'd3, 16'h8000));
    pending_requests.push_back(set_req(2'd1, 16'hFFFF));
    // interval of two: second tick sends; third tick ages past the timeout
    repeat (3) pending_requests.push_back(rand_item(REQ_TICK));
    pending_requests.push_back(rand_item(REQ_READ));
    pending_requests.push_back(rand_item(REQ_ZERO_ALL));
    pending_requests.push_back(rand_item(REQ_UNKNOWN_LO));
    wait_idle();

    // window at the top of the ID space, send on every tick, zero timeout
    set_config(1'b1, 11'd2046, 11'd2047, 16'd0, 24'd0);
    run_random(PHASE_ITEMS);

    // window at zero, longest interval, timeout that never expires
    set_config(1'b1, 11'd0, 11'd0, 16'hFFFF, 24'hFF_FFFF);
    run_random(PHASE_ITEMS);

    set_config(1'b1, 11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
               16'($urandom_range(1, 6)), 24'($urandom_range(0, 30)));
    run_random(PHASE_ITEMS);

    // bus off: only aging and command storage
    set_config(1'b0, 11'd700, 11'd1365, 16'd3, 24'd10);
    run_random(PHASE_ITEMS);

    set_config(1'b1, 11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
               16'd1, 24'($urandom_range(5, 100)));
    run_random(PHASE_ITEMS);

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
